### design/uitfr_pkg.sv
// Package for the UART idle-timeout frame receiver.
// Item kinds, reset values and default sizes; no dependencies.
package uitfr_pkg;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   localparam int BUF_DEPTH_DEFAULT = 256;
   localparam int IDLE_W = 15;
   localparam int LEN_W = 9;
   localparam int BYTE_W = 8;
   localparam logic [IDLE_W-1:0] IDLE_TICKS_RESET = 15'd5;

endpackage

### design/uitfr_if.sv
// Valid/ready channel interfaces of the frame receiver.
// Depends on uitfr_pkg for the item kind type and field widths.
interface uitfr_req_if;
   import uitfr_pkg::*;
   logic              valid;
   logic              ready;
   kind_type          kind;
   logic [BYTE_W-1:0] rx_byte;
   logic [BYTE_W-1:0] read_index;
   modport source(output valid, kind, rx_byte, read_index, input ready);
   modport sink(input valid, kind, rx_byte, read_index, output ready);
endinterface

interface uitfr_rsp_if;
   import uitfr_pkg::*;
   logic              valid;
   logic              ready;
   logic              frame_done;
   logic [LEN_W-1:0]  frame_length;
   logic [BYTE_W-1:0] read_data;
   modport source(output valid, frame_done, frame_length, read_data, input ready);
   modport sink(input valid, frame_done, frame_length, read_data, output ready);
endinterface

interface uitfr_csr_if;
   import uitfr_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDLE_W-1:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

### design/uart_idle_timeout_frame_receiver_unit.sv
// UART idle-timeout frame receiver: top level.
// Depends on uitfr_pkg, uitfr_if and uitfr_ram.
// The result of an item is registered and presented in the cycle after its transfer.
// Throughput: one item per cycle; req ready follows the result register
// (free, or being taken this cycle). The buffer read uses the RAM read port.
// Reset (synchronous) clears length, done, timer and sets idle_ticks to 5;
// buffer contents stay undefined until written.
module uart_idle_timeout_frame_receiver_unit #(
   parameter int BUF_DEPTH = uitfr_pkg::BUF_DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   uitfr_req_if.sink   req_chan,
   uitfr_rsp_if.source rsp_chan,
   uitfr_csr_if.sink   csr_chan
);
   import uitfr_pkg::*;

   localparam int AddrW = $clog2(BUF_DEPTH);
   localparam int CntW = $clog2(BUF_DEPTH + 1);
   localparam int ExtW = CntW + LEN_W;

   logic [IDLE_W-1:0] idle_ticks_ff;
   logic [CntW-1:0]   count_ff, count_in;
   logic              done_ff, done_in;
   logic              run_ff, run_in;
   logic [IDLE_W-1:0] idle_ff, idle_in;

   logic              rsp_valid_ff;
   logic              rsp_done_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic              rsp_sel_ff;

   logic              accept;
   logic              full;
   logic              we;
   logic              re;
   logic              in_range;
   logic [31:0]       idx_wide;
   logic [ExtW-1:0]   cnt_ext;
   logic [BYTE_W-1:0] ram_q;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && req_chan.ready;
   assign full = (count_ff == CntW'(BUF_DEPTH));
   assign idx_wide = 32'(req_chan.read_index);
   assign in_range = idx_wide < 32'(BUF_DEPTH);
   assign cnt_ext = ExtW'(count_in);

   always_comb begin
      count_in = count_ff;
      done_in = done_ff;
      run_in = run_ff;
      idle_in = idle_ff;
      we = 1'b0;
      if (accept) begin
         unique case (req_chan.kind)
            KIND_BYTE: begin
               if (!done_ff) begin
                  if (!full) begin
                     run_in = 1'b1;
                     idle_in = '0;
                     we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     done_in = 1'b1;
                  end
               end
            end
            KIND_TICK: begin
               if (run_ff) begin
                  if (idle_ff < idle_ticks_ff) begin
                     idle_in = idle_ff + 1'b1;
                  end else begin
                     run_in = 1'b0;
                     idle_in = '0;
                     done_in = 1'b1;
                  end
               end
            end
            KIND_READ: begin
            end
            KIND_CLEAR: begin
               count_in = '0;
               done_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign re = accept && (req_chan.kind == KIND_READ) && in_range;

   uitfr_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(BUF_DEPTH)
   ) u_buf (
      .clock(clock),
      .we(we),
      .waddr(count_ff[AddrW-1:0]),
      .wdata(req_chan.rx_byte),
      .re(re),
      .raddr(idx_wide[AddrW-1:0]),
      .rdata(ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff <= IDLE_TICKS_RESET;
         count_ff <= '0;
         done_ff <= 1'b0;
         run_ff <= 1'b0;
         idle_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            idle_ticks_ff <= csr_chan.data;
         end
         count_ff <= count_in;
         done_ff <= done_in;
         run_ff <= run_in;
         idle_ff <= idle_in;
         if (req_chan.ready) begin
            rsp_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_done_ff <= done_in;
         rsp_len_ff <= cnt_ext[LEN_W-1:0];
         rsp_sel_ff <= re;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.frame_done = rsp_done_ff;
   assign rsp_chan.frame_length = rsp_len_ff;
   assign rsp_chan.read_data = rsp_sel_ff ? ram_q : '0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(BUF_DEPTH))
      else $error("frame length beyond buffer depth");

   a_idle_stopped: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> (idle_ff == '0))
      else $error("idle timer holds a count while stopped");

   a_byte_store: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.kind == KIND_BYTE && !done_ff && !full)
      |=> (count_ff == $past(count_ff) + 1'b1) && run_ff)
      else $error("stored byte did not advance the frame length");

   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.kind == KIND_CLEAR)
      |=> rsp_valid_ff && !rsp_done_ff && (rsp_len_ff == '0))
      else $error("clear transfer did not report an empty frame");

endmodule

### design/uitfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module uitfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### dv/tb_uart_idle_timeout_frame_receiver_unit.sv
`timescale 1ns / 100ps
// Testbench for the UART idle-timeout frame receiver: directed and random item streams
// with random stalls, checked against a cycle-free frame tracker scoreboard.
// Depends on uitfr_pkg, the uitfr interfaces and the receiver top level.
module tb_uart_idle_timeout_frame_receiver_unit;
   import uitfr_pkg::*;

   localparam int DEPTH = BUF_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic              frame_done;
      logic [LEN_W-1:0]  frame_length;
      logic [BYTE_W-1:0] read_data;
   } frame_status_type;

   class frame_tracker_type;
      logic [BYTE_W-1:0] shadow_mem [DEPTH];
      logic [LEN_W-1:0]  length;
      bit                done;
      bit                running;
      logic [IDLE_W-1:0] idle_cnt;
      logic [IDLE_W-1:0] idle_lim;
      int                high_water;
      int                errors;
      frame_status_type  status_due [$];

      function new();
         length = '0;
         done = 0;
         running = 0;
         idle_cnt = '0;
         idle_lim = IDLE_TICKS_RESET;
         high_water = 0;
         errors = 0;
      endfunction

      function bit is_noop(kind_type k);
         return (k == KIND_BYTE && done) || (k == KIND_TICK && !running);
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      function void note_item(kind_type k, logic [BYTE_W-1:0] rx, logic [BYTE_W-1:0] ix);
         frame_status_type st;
         logic [BYTE_W-1:0] data;
         data = '0;
         case (k)
            KIND_BYTE: begin
               if (!done) begin
                  if (length < DEPTH) begin
                     running = 1;
                     idle_cnt = '0;
                     shadow_mem[length] = rx;
                     length = length + 1'b1;
                     if (int'(length) > high_water) high_water = int'(length);
                  end else begin
                     done = 1;
                  end
               end
            end
            KIND_TICK: begin
               if (running) begin
                  if (idle_cnt < idle_lim) begin
                     idle_cnt = idle_cnt + 1'b1;
                  end else begin
                     running = 0;
                     idle_cnt = '0;
                     done = 1;
                  end
               end
            end
            KIND_READ: begin
               if (int'(ix) < DEPTH) data = shadow_mem[ix];
            end
            default: begin
               length = '0;
               done = 0;
            end
         endcase
         st.frame_done = done;
         st.frame_length = length;
         st.read_data = data;
         status_due.push_back(st);
      endfunction

      function void check_status(frame_status_type got);
         frame_status_type want;
         if (status_due.size() == 0) begin
            $error("unexpected result: frame_done %0d frame_length %0d read_data %0d",
                   got.frame_done, got.frame_length, got.read_data);
            errors++;
            return;
         end
         want = status_due.pop_front();
         if (got.frame_done !== want.frame_done) begin
            $error("frame_done expected %0d actual %0d", want.frame_done, got.frame_done);
            errors++;
         end
         if (got.frame_length !== want.frame_length) begin
            $error("frame_length expected %0d actual %0d", want.frame_length, got.frame_length);
            errors++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data expected %0d actual %0d", want.read_data, got.read_data);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   uitfr_req_if req_bus ();
   uitfr_rsp_if rsp_bus ();
   uitfr_csr_if csr_bus ();

   frame_tracker_type tracker;
   int  cycles;
   int  useful_sent;
   bit  full_rate;
   bit  overflow_due;
   int  rsp_hold;

   uart_idle_timeout_frame_receiver_unit #(.BUF_DEPTH(DEPTH)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      frame_status_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_item(req_bus.kind, req_bus.rx_byte, req_bus.read_index);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.frame_done = rsp_bus.frame_done;
            got.frame_length = rsp_bus.frame_length;
            got.read_data = rsp_bus.read_data;
            tracker.check_status(got);
         end
      end
   end

   always @(negedge clock) begin
      if (full_rate) begin
         rsp_bus.ready <= 1'b1;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         rsp_hold = pick_gap();
      end
   end

   task automatic send_item(kind_type k, logic [BYTE_W-1:0] rx, logic [BYTE_W-1:0] ix);
      int gap;
      if (!tracker.is_noop(k)) useful_sent++;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind <= k;
      req_bus.rx_byte <= rx;
      req_bus.read_index <= ix;
      do @(posedge clock); while (!req_bus.ready);
      gap = full_rate ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_byte(logic [BYTE_W-1:0] rx);
      send_item(KIND_BYTE, rx, BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic send_clear();
      send_item(KIND_CLEAR, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic send_read(logic [BYTE_W-1:0] ix);
      send_item(KIND_READ, BYTE_W'($urandom_range(0, 255)), ix);
   endtask

   task automatic send_random_read();
      if (tracker.high_water > 0)
         send_read(BYTE_W'($urandom_range(0, tracker.high_water - 1)));
      else
         send_byte(BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
   endtask

   task automatic write_idle_ticks(logic [IDLE_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      tracker.idle_lim = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_frame();
      int n;
      int r;
      int ticks;
      if ($urandom_range(0, 9) < 7) send_clear();
      r = $urandom_range(0, 99);
      if (overflow_due) begin
         n = DEPTH + 1;
         overflow_due = 0;
      end else if (r < 90) begin
         n = $urandom_range(1, 16);
      end else if (r < 97) begin
         n = $urandom_range(17, DEPTH - 1);
      end else begin
         n = $urandom_range(DEPTH, DEPTH + 4);
      end
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 6) send_random_read();
         else if (r < 10) send_tick();
         send_byte(BYTE_W'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 4)) send_random_read();
      if (tracker.idle_lim <= 40)
         ticks = int'(tracker.idle_lim) + 1 + $urandom_range(0, 2);
      else
         ticks = $urandom_range(1, 30);
      if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, ticks);
      repeat (ticks) send_tick();
      repeat ($urandom_range(0, 3)) send_random_read();
   endtask

   task automatic send_noise();
      kind_type k;
      k = kind_type'($urandom_range(0, 3));
      if (k == KIND_READ)
         send_random_read();
      else
         send_item(k, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic run_phase(int budget);
      int start;
      bit paused;
      start = useful_sent;
      paused = 0;
      while (useful_sent - start < budget) begin
         if ($urandom_range(0, 99) < 80) send_frame();
         else send_noise();
         if (!paused && useful_sent - start >= budget / 2) begin
            wait_drained();
            paused = 1;
         end
      end
   endtask

   initial begin
      logic [IDLE_W-1:0] settings [6];
      tracker = new();
      cycles = 0;
      useful_sent = 0;
      full_rate = 0;
      overflow_due = 1;
      rsp_hold = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_BYTE;
      req_bus.rx_byte = '0;
      req_bus.read_index = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_tick();
      send_clear();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_byte(8'h5A);
      for (int i = 0; i < 4; i++) send_read(BYTE_W'(i));
      repeat (6) send_tick();
      send_byte(8'h3C);
      send_read(8'd1);
      send_clear();

      write_idle_ticks('0);
      send_byte(8'h11);
      send_clear();
      send_tick();
      send_clear();

      settings[0] = 15'h7FFF;
      settings[1] = IDLE_W'($urandom_range(1, 8));
      settings[2] = '0;
      settings[3] = IDLE_TICKS_RESET;
      settings[4] = IDLE_W'($urandom_range(0, 3));
      settings[5] = IDLE_W'($urandom_range(9, 30));
      for (int p = 0; p < 6; p++) begin
         write_idle_ticks(settings[p]);
         full_rate = (p == 2);
         run_phase(130);
      end
      full_rate = 0;

      wait_drained();
      repeat (5) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
